FILE: hw/rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and codes for the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int FUNC_W   = 3;
  localparam int PID_W    = 4;
  localparam int SIZE_W   = 7;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 6;

  localparam logic [FUNC_W-1:0] FUNC_FIRST   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEST    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WORST   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_COMPACT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd2;

  typedef logic [1:0] policy_t;
  localparam policy_t POL_FIRST = 2'd0;
  localparam policy_t POL_BEST  = 2'd1;
  localparam policy_t POL_WORST = 2'd2;

  // One map cell: owned flag and owner pid. A free cell is all zero.
  typedef struct packed {
    logic             owned;
    logic [PID_W-1:0] pid;
  } cell_t;

  localparam cell_t CELL_FREE = '0;
  localparam cell_t CELL_BLOCK = '{owned: 1'b1, pid: '0};

  typedef struct packed {
    logic shift;   // rotate the ring by one toward cell 0
    logic sort;    // odd-even exchange step
    logic phase;   // which pairs exchange this step
  } cell_ctrl_t;

  typedef struct packed {
    logic    start;    // clear hole tracking
    logic    scan;     // track holes on the cell at the head
    logic    flush;    // close the run still open at the top
    logic    write;    // claim cells of the chosen hole
    logic    drop;     // free cells of the pid
    policy_t policy;
  } head_ctrl_t;

endpackage

FILE: hw/rtl/cfa_if.sv
// ----------------------------------------------------------------------------
// cfa_if
// Command and response channels of the contiguous fit allocator.
// ----------------------------------------------------------------------------
interface cfa_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [cfa_pkg::FUNC_W-1:0] func;
  logic [cfa_pkg::PID_W-1:0]  pid;
  logic [cfa_pkg::SIZE_W-1:0] size;

  modport source (output valid, func, pid, size, input ready);
  modport sink   (input valid, func, pid, size, output ready);
endinterface

interface cfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cfa_pkg::STATUS_W-1:0] status;
  logic [cfa_pkg::ADDR_W-1:0]   start_addr;

  modport source (output valid, status, start_addr, input ready);
  modport sink   (input valid, status, start_addr, output ready);
endinterface

FILE: hw/rtl/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Contiguous cell allocator (first, best, worst fit), release and compaction.
// ----------------------------------------------------------------------------
// Unused func codes are rejected without a pass over the ring.
// Throughput: one command at a time; the cell ring makes a full rotation (or
//   MEM_CELLS odd-even exchange steps) per pass, an accepted allocation needs two passes.
// Reset: rst_n synchronous, active low; every cell becomes free at once.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
  parameter int MEM_CELLS = 64
) (
  input  logic clk,
  input  logic rst_n,
  cfa_cmd_if.sink   in_if,
  cfa_rsp_if.source out_if
);
  import cfa_pkg::*;

  localparam int AW = $clog2(MEM_CELLS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FLUSH, S_DECIDE, S_WRITE, S_RELEASE, S_SORT, S_FIN
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       cnt_r;
  logic [FUNC_W-1:0]   func_r;
  logic [PID_W-1:0]    pid_r;
  logic [SIZE_W-1:0]   size_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;

  logic       last;
  cell_ctrl_t cctrl;
  head_ctrl_t hctrl;
  cell_t      cell_q [MEM_CELLS];
  cell_t      tail;
  logic       fits;
  logic [AW-1:0] pick_start;

  assign last = (cnt_r == AW'(MEM_CELLS - 1));

  // Cell ring controls: rotate during the scan, write-back and release passes,
  // odd-even exchange steps for compaction (MEM_CELLS steps sort any map).
  always_comb begin
    cctrl.shift = (state_r == S_SCAN) || (state_r == S_WRITE) || (state_r == S_RELEASE);
    cctrl.sort  = (state_r == S_SORT);
    cctrl.phase = cnt_r[0];
  end

  always_comb begin
    hctrl.start  = (state_r == S_IDLE);
    hctrl.scan   = (state_r == S_SCAN);
    hctrl.flush  = (state_r == S_FLUSH);
    hctrl.write  = (state_r == S_WRITE);
    hctrl.drop   = (state_r == S_RELEASE);
    case (func_r)
      FUNC_FIRST: hctrl.policy = POL_FIRST;
      FUNC_BEST:  hctrl.policy = POL_BEST;
      default:    hctrl.policy = POL_WORST;
    endcase
  end

  // Ring of cells: cell 0 feeds the head, the head feeds the top cell.
  for (genvar k = 0; k < MEM_CELLS; k++) begin : g_cell
    cell_t left_in, right_in;
    if (k == 0) begin : g_lo
      assign left_in = CELL_BLOCK;
    end else begin : g_lo
      assign left_in = cell_q[k-1];
    end
    if (k == MEM_CELLS - 1) begin : g_hi
      assign right_in = cctrl.sort ? CELL_FREE : tail;
    end else begin : g_hi
      assign right_in = cell_q[k+1];
    end
    cfa_cell #(.PARITY(k[0])) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cctrl),
      .nb_left  (left_in),
      .nb_right (right_in),
      .cell_q   (cell_q[k])
    );
  end

  cfa_head #(.MEM_CELLS(MEM_CELLS)) u_head (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (hctrl),
    .idx        (cnt_r),
    .cell0      (cell_q[0]),
    .pid        (pid_r),
    .size       (size_r),
    .tail       (tail),
    .fits       (fits),
    .pick_start (pick_start)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load the result register from S_FIN, else drop it once taken
      if (state_r == S_FIN) begin
        if (!out_valid_r || out_if.ready) out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_if.valid) begin
            func_r <= in_if.func;
            pid_r  <= in_if.pid;
            size_r <= in_if.size;
            res_addr_r <= '0;
            case (in_if.func)
              FUNC_FIRST, FUNC_BEST, FUNC_WORST: state_r <= S_SCAN;
              FUNC_RELEASE: state_r <= S_RELEASE;
              FUNC_COMPACT: state_r <= S_SORT;
              default: begin
                res_status_r <= ST_REJECT;
                state_r      <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (last) state_r <= S_FLUSH;
        end
        S_FLUSH: begin
          cnt_r   <= '0;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (fits) begin
            res_status_r <= ST_ACCEPT;
            res_addr_r   <= ADDR_W'(pick_start);
            state_r      <= S_WRITE;
          end else begin
            res_status_r <= ST_REJECT;
            state_r      <= S_FIN;
          end
        end
        S_WRITE: begin
          cnt_r <= cnt_r + 1'b1;
          if (last) state_r <= S_FIN;
        end
        S_RELEASE, S_SORT: begin
          cnt_r <= cnt_r + 1'b1;
          if (last) begin
            res_status_r <= ST_DONE;
            state_r      <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid_r || out_if.ready) begin
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.start_addr = out_addr_r;

endmodule

FILE: hw/rtl/cfa_cell.sv
// ----------------------------------------------------------------------------
// cfa_cell
// One map cell: rotates toward its lower neighbor or does an odd-even exchange.
// ----------------------------------------------------------------------------
module cfa_cell #(
  parameter bit PARITY = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfa_pkg::cell_ctrl_t ctrl,
  input  cfa_pkg::cell_t      nb_left,
  input  cfa_pkg::cell_t      nb_right,
  output cfa_pkg::cell_t      cell_q
);
  import cfa_pkg::*;

  cell_t cell_r, cell_nxt;

  always_comb begin
    cell_nxt = cell_r;
    if (ctrl.shift) begin
      cell_nxt = nb_right;
    end else if (ctrl.sort) begin
      if (PARITY == ctrl.phase) begin
        // lower member of the pair: pull an owned cell down over a free one
        if (!cell_r.owned && nb_right.owned) cell_nxt = nb_right;
      end else begin
        if (!nb_left.owned && cell_r.owned) cell_nxt = nb_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= CELL_FREE;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_q = cell_r;

endmodule

FILE: hw/rtl/cfa_head.sv
// ----------------------------------------------------------------------------
// cfa_head
// Ring head: hole tracking during a scan, claim on write-back, release on the release pass.
// ----------------------------------------------------------------------------
module cfa_head #(
  parameter int MEM_CELLS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfa_pkg::head_ctrl_t         ctrl,
  input  logic [$clog2(MEM_CELLS)-1:0] idx,
  input  cfa_pkg::cell_t              cell0,
  input  logic [cfa_pkg::PID_W-1:0]   pid,
  input  logic [cfa_pkg::SIZE_W-1:0]  size,
  output cfa_pkg::cell_t              tail,
  output logic                        fits,
  output logic [$clog2(MEM_CELLS)-1:0] pick_start
);
  import cfa_pkg::*;

  localparam int AW = $clog2(MEM_CELLS);
  localparam int LW = $clog2(MEM_CELLS + 1);
  localparam int CW = ((LW > SIZE_W) ? LW : SIZE_W) + 1;

  logic [AW-1:0] run_start_r, run_start_nxt;
  logic [LW-1:0] run_len_r, run_len_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] pick_start_r, pick_start_nxt;
  logic [LW-1:0] pick_len_r, pick_len_nxt;

  logic [CW-1:0] size_x, run_x, pick_x, lo_x, hi_x, idx_x;
  logic          do_close, take, in_run;
  cell_t         own_cell;

  assign size_x = CW'(size);
  assign run_x  = CW'(run_len_r);
  assign pick_x = CW'(pick_len_r);
  assign idx_x  = CW'(idx);
  assign lo_x   = CW'(pick_start_r);
  assign hi_x   = lo_x + size_x;

  assign do_close = ctrl.flush || (ctrl.scan && cell0.owned);

  always_comb begin
    case (ctrl.policy)
      POL_FIRST: take = !found_r && (run_x >= size_x);
      POL_BEST:  take = (run_x >= size_x) && (!found_r || run_x < pick_x);
      default:   take = !found_r || run_x > pick_x;
    endcase
  end

  always_comb begin
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    found_nxt      = found_r;
    pick_start_nxt = pick_start_r;
    pick_len_nxt   = pick_len_r;
    if (ctrl.start) begin
      run_len_nxt  = '0;
      found_nxt    = 1'b0;
      pick_len_nxt = '0;
    end else if (do_close) begin
      if (run_len_r != '0 && take) begin
        found_nxt      = 1'b1;
        pick_start_nxt = run_start_r;
        pick_len_nxt   = run_len_r;
      end
      run_len_nxt = '0;
    end else if (ctrl.scan) begin
      if (run_len_r == '0) run_start_nxt = idx;
      run_len_nxt = run_len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r  <= '0;
      found_r    <= 1'b0;
      pick_len_r <= '0;
    end else begin
      run_len_r  <= run_len_nxt;
      found_r    <= found_nxt;
      pick_len_r <= pick_len_nxt;
    end
    run_start_r  <= run_start_nxt;
    pick_start_r <= pick_start_nxt;
  end

  assign in_run   = (idx_x >= lo_x) && (idx_x < hi_x);
  assign own_cell = '{owned: 1'b1, pid: pid};

  always_comb begin
    tail = cell0;
    if (ctrl.write && in_run) begin
      tail = own_cell;
    end else if (ctrl.drop && cell0 == own_cell) begin
      tail = CELL_FREE;
    end
  end

  assign fits       = found_r && (size != '0) && (pick_x >= size_x);
  assign pick_start = pick_start_r;

endmodule

FILE: hw/rtl/cfa_checker.sv
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks for the contiguous fit allocator.
// ----------------------------------------------------------------------------
module cfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cfa_pkg::STATUS_W-1:0] out_status,
  input logic [cfa_pkg::ADDR_W-1:0]   out_start_addr
);
  import cfa_pkg::*;

  // one command in flight: no new transaction right after one is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ACCEPT |-> out_start_addr == '0)
    else $error("start address set on a non-accepted result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_ACCEPT || out_status == ST_REJECT ||
                   out_status == ST_DONE))
    else $error("bad status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_start_addr))
    else $error("stalled result changed");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_status     (out_if.status),
  .out_start_addr (out_if.start_addr)
);

FILE: tb/tb_contiguous_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_fit_allocator
// Drives fit, release, compact and unused-code commands into the allocator, models its
// cell map to predict each response, and compares responses in order.
// ----------------------------------------------------------------------------
module tb_contiguous_fit_allocator;
  import cfa_pkg::*;

  localparam int CELLS    = 64;
  localparam int IDLE_MAX = 4000;
  localparam int TAIL     = 2 * CELLS + 20;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [PID_W-1:0]    pid;
    logic [SIZE_W-1:0]   size;
    logic                known;   // expected response typed in the row
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
  } row_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  cfa_cmd_if cmd ();
  cfa_rsp_if rsp ();

  contiguous_fit_allocator #(.MEM_CELLS(CELLS)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(cmd.sink), .out_if(rsp.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the cell map, advanced once per accepted command.
  cell_t cell_map [CELLS];
  rsp_t  pending_rsp [$];
  int    fail_cnt = 0;
  int    idle_cycles = 0;
  bit    stim_done = 0;

  // Gap length: mostly zero or short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one command to the shadow map and return the response it yields.
  function automatic rsp_t alloc_step(logic [FUNC_W-1:0] f, logic [PID_W-1:0] p,
                                      logic [SIZE_W-1:0] sz);
    rsp_t r;
    int   run_s, run_l, pick_s, pick_l, w;
    bit   found, take, free_c;
    r.status = ST_REJECT;
    r.addr   = '0;
    found = 0; pick_s = 0; pick_l = 0; run_s = 0; run_l = 0;
    if (f == FUNC_FIRST || f == FUNC_BEST || f == FUNC_WORST) begin
      for (int i = 0; i <= CELLS; i++) begin
        free_c = (i < CELLS) && !cell_map[i].owned;
        if (free_c) begin
          if (run_l == 0) run_s = i;
          run_l++;
        end else if (run_l > 0) begin
          if (f == FUNC_FIRST)
            take = !found && run_l >= sz;
          else if (f == FUNC_BEST)
            take = run_l >= sz && (!found || run_l < pick_l);
          else
            take = !found || run_l > pick_l;
          if (take) begin
            found = 1; pick_s = run_s; pick_l = run_l;
          end
          run_l = 0;
        end
      end
      if (sz != 0 && found && pick_l >= sz) begin
        for (int i = pick_s; i < pick_s + sz; i++) begin
          cell_map[i].owned = 1'b1;
          cell_map[i].pid   = p;
        end
        r.status = ST_ACCEPT;
        r.addr   = pick_s[ADDR_W-1:0];
      end
    end else if (f == FUNC_RELEASE) begin
      for (int i = 0; i < CELLS; i++)
        if (cell_map[i].owned && cell_map[i].pid == p) cell_map[i] = CELL_FREE;
      r.status = ST_DONE;
    end else if (f == FUNC_COMPACT) begin
      w = 0;
      for (int i = 0; i < CELLS; i++)
        if (cell_map[i].owned) cell_map[w++] = cell_map[i];
      for (; w < CELLS; w++) cell_map[w] = CELL_FREE;
      r.status = ST_DONE;
    end
    return r;
  endfunction

  // Directed rows: empty map, extremes, every func, unused codes.
  row_t dir_rows [] = '{
    '{FUNC_FIRST,   4'd0,  7'd0,   1'b1, ST_REJECT, 6'd0},  // zero size
    '{FUNC_FIRST,   4'd1,  7'd65,  1'b1, ST_REJECT, 6'd0},  // oversize
    '{FUNC_WORST,   4'd15, 7'd127, 1'b1, ST_REJECT, 6'd0},
    '{FUNC_FIRST,   4'd1,  7'd64,  1'b1, ST_ACCEPT, 6'd0},  // whole map
    '{FUNC_BEST,    4'd2,  7'd1,   1'b1, ST_REJECT, 6'd0},  // full map
    '{FUNC_RELEASE, 4'd1,  7'd0,   1'b1, ST_DONE,   6'd0},
    '{FUNC_FIRST,   4'd3,  7'd63,  1'b1, ST_ACCEPT, 6'd0},  // lone top cell left
    '{FUNC_BEST,    4'd4,  7'd1,   1'b1, ST_ACCEPT, 6'd63},
    '{FUNC_RELEASE, 4'd3,  7'd0,   1'b1, ST_DONE,   6'd0},
    '{FUNC_FIRST,   4'd5,  7'd10,  1'b0, '0, '0},
    '{FUNC_FIRST,   4'd6,  7'd5,   1'b0, '0, '0},
    '{FUNC_FIRST,   4'd7,  7'd20,  1'b0, '0, '0},
    '{FUNC_RELEASE, 4'd5,  7'd0,   1'b0, '0, '0},
    '{FUNC_BEST,    4'd8,  7'd4,   1'b0, '0, '0},
    '{FUNC_WORST,   4'd9,  7'd3,   1'b0, '0, '0},
    '{FUNC_WORST,   4'd10, 7'd40,  1'b0, '0, '0},
    '{FUNC_COMPACT, 4'd0,  7'd0,   1'b1, ST_DONE,   6'd0},
    '{FUNC_WORST,   4'd10, 7'd26,  1'b0, '0, '0},
    '{3'd5,         4'd2,  7'd3,   1'b1, ST_REJECT, 6'd0},
    '{3'd6,         4'd0,  7'd0,   1'b1, ST_REJECT, 6'd0},
    '{3'd7,         4'd15, 7'd127, 1'b1, ST_REJECT, 6'd0},
    '{FUNC_COMPACT, 4'd0,  7'd0,   1'b1, ST_DONE,   6'd0}
  };

  // Send one command; queue its predicted response and check a typed row.
  task automatic send_cmd(row_t row);
    rsp_t pred;
    repeat (gap_len()) @(negedge clk) cmd.valid <= 1'b0;
    @(negedge clk);
    cmd.valid <= 1'b1;
    cmd.func  <= row.func;
    cmd.pid   <= row.pid;
    cmd.size  <= row.size;
    do @(posedge clk); while (!cmd.ready);
    pred = alloc_step(row.func, row.pid, row.size);
    if (row.known && pred != {row.status, row.addr}) begin
      $error("directed row: expected status %0d addr %0d, model gives %0d %0d",
             row.status, row.addr, pred.status, pred.addr);
      fail_cnt++;
    end
    pending_rsp.push_back(pred);
    @(negedge clk) cmd.valid <= 1'b0;
  endtask

  initial begin
    row_t r;
    int   pick;
    cmd.valid = 1'b0;
    cmd.func  = '0;
    cmd.pid   = '0;
    cmd.size  = '0;
    for (int i = 0; i < CELLS; i++) cell_map[i] = CELL_FREE;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[i]) send_cmd(dir_rows[i]);

    // Random part: mostly small allocations, releases to reopen holes.
    for (int n = 0; n < 1200; n++) begin
      r = '0;
      pick = $urandom_range(0, 99);
      r.pid = PID_W'($urandom_range(0, 15));
      if (pick < 60) begin
        r.func = FUNC_W'($urandom_range(0, 2));
        if ($urandom_range(0, 19) == 0) r.size = SIZE_W'($urandom_range(0, 127));
        else r.size = SIZE_W'($urandom_range(1, 12));
      end else if (pick < 85) begin
        r.func = FUNC_RELEASE;
        r.size = SIZE_W'($urandom_range(0, 127));
      end else if (pick < 95) begin
        r.func = FUNC_COMPACT;
        r.size = SIZE_W'($urandom_range(0, 127));
      end else begin
        r.func = FUNC_W'($urandom_range(5, 7));
        r.size = SIZE_W'($urandom_range(0, 127));
      end
      send_cmd(r);
    end
    stim_done = 1;
  end

  // Response side: random backpressure and in-order comparison.
  initial begin
    rsp_t exp_rsp;
    int   g;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          rsp.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      if (rst_n && rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("response with none pending: status %0d addr %0d",
                 rsp.status, rsp.start_addr);
          fail_cnt++;
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
            fail_cnt++;
          end
          if (rsp.start_addr !== exp_rsp.addr) begin
            $error("start_addr: expected %0d, got %0d", exp_rsp.addr, rsp.start_addr);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (stim_done && pending_rsp.size() == 0) begin
        repeat (TAIL) @(posedge clk);
        if (fail_cnt == 0 && pending_rsp.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
